// ===== sv/ups2x_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ups2x_pkg: shared types and constants of the 2x image upsampler
// Word formats, register indexes and the work record that the front part
// hands to the back part through the queue.
// ----------------------------------------------------------------------------
package ups2x_pkg;

   // Default line store depth (maximum source width in pixels).
   localparam int MAX_WIDTH_DEF = 2048;

   // Height saturates at this many source rows.
   localparam int HEIGHT_LIMIT = 4096;

   // Depth of the work queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Register reset values.
   localparam logic [11:0] SRC_WIDTH_RST  = 12'd640;
   localparam logic [12:0] SRC_HEIGHT_RST = 13'd480;

   // Configuration port widths and register indexes.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT = 4'd1;

   // Input word: one source pixel.
   typedef struct packed {
      logic [7:0] ch0_in;
      logic [7:0] ch1_in;
      logic [7:0] ch2_in;
   } req_type;

   // Output word: one upsampled pixel with its coordinates.
   typedef struct packed {
      logic [7:0]  ch0_out;
      logic [7:0]  ch1_out;
      logic [7:0]  ch2_out;
      logic [12:0] out_row;
      logic [11:0] out_col;
      logic        last_of_run;
      logic        last_of_frame;
   } rsp_type;

   // Pixel: channel 0 in bits 7..0, channel 1 in 15..8, channel 2 in 23..16.
   typedef logic [23:0] pix_type;

   // Position flags of a source pixel within the frame.
   typedef struct packed {
      logic has_up;     // a source row lies above
      logic has_left;   // a source column lies to the left
      logic ext_row;    // last row of an even height: one more output row
      logic ext_col;    // last column of an even width: one more output column
      logic frame_end;  // last source pixel of the frame
   } flags_type;

   // Work record for one source pixel.
   typedef struct packed {
      pix_type     upleft;
      pix_type     up;
      pix_type     left;
      pix_type     cur;
      logic [12:0] row2;
      logic [11:0] col2;
      flags_type   flags;
   } job_type;

endpackage

// ===== sv/ups2x_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ups2x_front: input side of the 2x upsampler
// Holds the configuration registers and frame counters, keeps the previous
// source row in a line memory and builds one work record per source pixel.
// ----------------------------------------------------------------------------
module ups2x_front #(
   parameter int MAX_WIDTH = ups2x_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ups2x_pkg::req_type                    req_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ups2x_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ups2x_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                  queue_almost_full,
   output logic                                  push,
   output ups2x_pkg::job_type                    push_job
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [11:0]           src_width_ff;
   logic [12:0]           src_height_ff;
   logic [CW-1:0]         col_ff;
   logic [11:0]           row_ff;
   logic [CW:0]           w_eff;
   logic [12:0]           h_eff;
   logic                  last_col;
   logic                  last_row;
   logic                  accept;
   logic                  csr_hit;
   logic [CW:0]           col_twice;

   ups2x_pkg::pix_type    line_mem [MAX_WIDTH];
   ups2x_pkg::pix_type    up_rd_ff;
   ups2x_pkg::pix_type    cur_pix;

   logic                  a_valid_ff;
   ups2x_pkg::pix_type    a_cur_ff;
   ups2x_pkg::flags_type  a_flags_ff;
   ups2x_pkg::flags_type  flags_in;
   logic [12:0]           a_row2_ff;
   logic [11:0]           a_col2_ff;
   ups2x_pkg::pix_type    left_ff;
   ups2x_pkg::pix_type    upleft_ff;
   ups2x_pkg::pix_type    up_eff;

   // Registers are always writable; the queue level throttles the input.
   assign csr_ready = 1'b1;
   assign req_stall = queue_almost_full;
   assign accept    = req_valid && !req_stall;
   assign cur_pix   = {req_data.ch2_in, req_data.ch1_in, req_data.ch0_in};

   // A write to a defined register restarts the frame.
   always_comb begin
      case (csr_index)
         ups2x_pkg::CSR_SRC_WIDTH:  csr_hit = csr_valid;
         ups2x_pkg::CSR_SRC_HEIGHT: csr_hit = csr_valid;
         default:                   csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= ups2x_pkg::SRC_WIDTH_RST;
         src_height_ff <= ups2x_pkg::SRC_HEIGHT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            ups2x_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[11:0];
            ups2x_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // Effective frame size: zero counts as one, large values saturate.
   always_comb begin
      if (src_width_ff == 12'd0) begin
         w_eff = (CW+1)'(1);
      end else if (32'(src_width_ff) > MAX_WIDTH) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW+1)'(src_width_ff);
      end
      if (src_height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (32'(src_height_ff) > ups2x_pkg::HEIGHT_LIMIT) begin
         h_eff = 13'(ups2x_pkg::HEIGHT_LIMIT);
      end else begin
         h_eff = src_height_ff;
      end
   end

   assign last_col = ((CW+1)'(col_ff) == w_eff - (CW+1)'(1));
   assign last_row = (13'(row_ff) == h_eff - 13'd1);

   // Position counters of the next source pixel.
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? 12'd0 : row_ff + 12'd1;
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // Line memory: read the pixel above, then overwrite it with this one.
   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff         <= line_mem[col_ff];
         line_mem[col_ff] <= cur_pix;
      end
   end

   assign col_twice = {col_ff, 1'b0};

   always_comb begin
      flags_in.has_up    = (row_ff != 12'd0);
      flags_in.has_left  = (col_ff != '0);
      flags_in.ext_row   = last_row && !h_eff[0];
      flags_in.ext_col   = last_col && !w_eff[0];
      flags_in.frame_end = last_row && last_col;
   end

   // Stage that holds the pixel while the line memory is read.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cur_ff   <= cur_pix;
         a_flags_ff <= flags_in;
         a_row2_ff  <= {row_ff, 1'b0};
         a_col2_ff  <= 12'(col_twice);
      end
   end

   // The first source row has nothing above it.
   assign up_eff = a_flags_ff.has_up ? up_rd_ff : '0;

   // Neighbor pixels of the previous source column.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         upleft_ff <= '0;
      end else if (a_valid_ff) begin
         left_ff   <= a_cur_ff;
         upleft_ff <= up_eff;
      end
   end

   assign push = a_valid_ff;

   always_comb begin
      push_job.upleft = upleft_ff;
      push_job.up     = up_eff;
      push_job.left   = left_ff;
      push_job.cur    = a_cur_ff;
      push_job.row2   = a_row2_ff;
      push_job.col2   = a_col2_ff;
      push_job.flags  = a_flags_ff;
   end

endmodule

// ===== sv/ups2x_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ups2x_queue: work queue between front and back
// A small first-in first-out buffer of work records. It reports almost full
// one entry early so that the record in flight in the front always fits.
// ----------------------------------------------------------------------------
module ups2x_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ups2x_pkg::job_type  push_job,
   input  logic                pop,
   output ups2x_pkg::job_type  head_job,
   output logic                not_empty,
   output logic                almost_full
);

   localparam int PW = $clog2(ups2x_pkg::QUEUE_DEPTH);
   localparam int NW = $clog2(ups2x_pkg::QUEUE_DEPTH + 1);

   ups2x_pkg::job_type  slots [ups2x_pkg::QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff;
   logic [PW-1:0]       rd_ptr_ff;
   logic [NW-1:0]       count_ff;

   assign head_job    = slots[rd_ptr_ff];
   assign not_empty   = (count_ff != '0);
   assign almost_full = (count_ff >= NW'(ups2x_pkg::QUEUE_DEPTH - 1));

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(ups2x_pkg::QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(ups2x_pkg::QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

endmodule

// ===== sv/ups2x_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ups2x_back: output side of the 2x upsampler
// Walks the output pixels of the work record at the queue head, one per
// cycle while the output is not stalled, in row then column order, and computes each rounded mean.
// ----------------------------------------------------------------------------
module ups2x_back (
   input  logic                clock,
   input  logic                reset,
   input  ups2x_pkg::job_type  job,
   input  logic                job_valid,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ups2x_pkg::rsp_type  rsp_data
);

   // Mean of the chosen neighbors, rounded to nearest with ties to even.
   function automatic logic [7:0] chan_mean(input logic [7:0] ul, input logic [7:0] up,
                                            input logic [7:0] lf, input logic [7:0] cu,
                                            input logic rb, input logic cb);
      logic [9:0] sum;
      logic [9:0] q;
      logic       rnd;
      sum = 10'(cu) + (cb ? 10'(lf) : 10'd0) + (rb ? 10'(up) : 10'd0)
            + ((rb && cb) ? 10'(ul) : 10'd0);
      if (rb && cb) begin
         q   = sum >> 2;
         rnd = (sum[1:0] == 2'b11) || ((sum[1:0] == 2'b10) && q[0]);
      end else if (rb || cb) begin
         q   = sum >> 1;
         rnd = sum[0] && q[0];
      end else begin
         q   = sum;
         rnd = 1'b0;
      end
      return 8'(q + 10'(rnd));
   endfunction

   logic               rsp_valid_ff;
   ups2x_pkg::rsp_type rsp_data_ff;
   ups2x_pkg::rsp_type rsp_data_in;
   logic [1:0]         ri_ff;
   logic [1:0]         ci_ff;
   logic [1:0]         row_kind;
   logic [1:0]         col_kind;
   logic               ri_last;
   logic               ci_last;
   logic               run_last;
   logic               row_both;
   logic               col_both;
   logic               advance;
   logic               fire;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = job_valid && advance;

   // Step indexes map to output positions: minus one, even, plus one.
   assign row_kind = ri_ff + {1'b0, !job.flags.has_up};
   assign col_kind = ci_ff + {1'b0, !job.flags.has_left};
   assign ri_last  = (ri_ff == 2'(job.flags.has_up) + 2'(job.flags.ext_row));
   assign ci_last  = (ci_ff == 2'(job.flags.has_left) + 2'(job.flags.ext_col));
   assign run_last = ri_last && ci_last;
   assign row_both = (row_kind == 2'd0);
   assign col_both = (col_kind == 2'd0);
   assign pop      = fire && run_last;

   // Next output word.
   always_comb begin
      rsp_data_in.ch0_out = chan_mean(job.upleft[7:0], job.up[7:0], job.left[7:0],
                                      job.cur[7:0], row_both, col_both);
      rsp_data_in.ch1_out = chan_mean(job.upleft[15:8], job.up[15:8], job.left[15:8],
                                      job.cur[15:8], row_both, col_both);
      rsp_data_in.ch2_out = chan_mean(job.upleft[23:16], job.up[23:16], job.left[23:16],
                                      job.cur[23:16], row_both, col_both);
      case (row_kind)
         2'd0:    rsp_data_in.out_row = job.row2 - 13'd1;
         2'd1:    rsp_data_in.out_row = job.row2;
         default: rsp_data_in.out_row = job.row2 + 13'd1;
      endcase
      case (col_kind)
         2'd0:    rsp_data_in.out_col = job.col2 - 12'd1;
         2'd1:    rsp_data_in.out_col = job.col2;
         default: rsp_data_in.out_col = job.col2 + 12'd1;
      endcase
      rsp_data_in.last_of_run   = run_last;
      rsp_data_in.last_of_frame = run_last && job.flags.frame_end;
   end

   // Position within the current record.
   always_ff @(posedge clock) begin
      if (reset) begin
         ri_ff <= '0;
         ci_ff <= '0;
      end else if (fire) begin
         if (run_last) begin
            ri_ff <= '0;
            ci_ff <= '0;
         end else if (ci_last) begin
            ri_ff <= ri_ff + 2'd1;
            ci_ff <= '0;
         end else begin
            ci_ff <= ci_ff + 2'd1;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/image_upsample_2x_interpolate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_upsample_2x_interpolate: 2x upsampler with neighbor averaging
// Top level: front part, work queue and back part.
// ----------------------------------------------------------------------------
// Each source pixel produces between one and nine output words (four in the
// interior of the image), and the back part emits one output word per cycle
// while the output is not stalled. A source pixel is written into the work
// queue in the cycle after it is accepted (that cycle is the line memory
// read), and its first output word then passes through the queue and the
// output register. The queue holds four pixels, so input keeps flowing while
// the output is stalled for a short while. Register writes take effect at
// once and restart the frame; they are expected only while no pixel is in
// flight. The line memory needs no clearing: the value read for the first
// row of a frame is never used.
module image_upsample_2x_interpolate #(
   parameter int MAX_WIDTH = ups2x_pkg::MAX_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ups2x_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ups2x_pkg::rsp_type                 rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ups2x_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ups2x_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic               push;
   ups2x_pkg::job_type push_job;
   logic               pop;
   ups2x_pkg::job_type head_job;
   logic               not_empty;
   logic               almost_full;

   // Input side: counters, line memory, work records.
   ups2x_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .queue_almost_full (almost_full),
      .push              (push),
      .push_job          (push_job)
   );

   // Work queue.
   ups2x_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_job    (push_job),
      .pop         (pop),
      .head_job    (head_job),
      .not_empty   (not_empty),
      .almost_full (almost_full)
   );

   // Output side: one output word per cycle while the output is not stalled.
   ups2x_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_valid (not_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/ups2x_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ups2x_checker: port checks of the 2x upsampler
// Watches the output channel of the top level over time.
// ----------------------------------------------------------------------------
module ups2x_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  ups2x_pkg::rsp_type rsp_data
);

   // A stalled output word stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("output word changed while stalled");

   // The last word of a frame is always the last word of its pixel.
   a_frame_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_frame |-> rsp_data.last_of_run)
      else $error("frame end without run end");

   // Reset leaves no output word pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word valid after reset");

endmodule

bind image_upsample_2x_interpolate ups2x_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the 2x image upsampler
// Source pixels go in through the request channel. The upsampled output words
// are checked field by field against a behavioral model of the upsampler that
// runs inside this bench. Directed tests cover reset size, tiny and
// saturated sizes, rounding ties and the register restart rule. A random test
// then runs many small frames under random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_PIXELS  = 70;
   localparam logic [ups2x_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 4'd2;

   logic                              clock;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   ups2x_pkg::req_type                req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   ups2x_pkg::rsp_type                rsp_data;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [ups2x_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ups2x_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Upsampler model state and register copies.
   ups2x_pkg::pix_type prior_row [ups2x_pkg::MAX_WIDTH_DEF];
   ups2x_pkg::pix_type left_px;
   ups2x_pkg::pix_type upleft_px;
   int unsigned        next_col;
   int unsigned        next_row;
   int unsigned        reg_width;
   int unsigned        reg_height;

   // Output words predicted but not yet seen, oldest first.
   ups2x_pkg::rsp_type pending_pixels [$];

   // Run statistics.
   int unsigned mismatches    = 0;
   int unsigned words_checked = 0;
   int unsigned pixels_sent   = 0;
   int unsigned reg_writes    = 0;
   int unsigned idle_cycles   = 0;

   // When set, the matching side never waits.
   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;

   image_upsample_2x_interpolate dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Upsampler model
   // ------------------------------------------------------------------------

   function automatic int unsigned eff_width();
      int unsigned w;
      w = reg_width;
      if (w == 0) w = 1;
      if (w > ups2x_pkg::MAX_WIDTH_DEF) w = ups2x_pkg::MAX_WIDTH_DEF;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = reg_height;
      if (h == 0) h = 1;
      if (h > ups2x_pkg::HEIGHT_LIMIT) h = ups2x_pkg::HEIGHT_LIMIT;
      return h;
   endfunction

   // Mean of n samples, rounded to nearest with ties to even.
   function automatic logic [7:0] mean_rne(input int unsigned sum, input int unsigned n);
      int unsigned q;
      int unsigned rem;
      q   = sum / n;
      rem = sum % n;
      if (2 * rem > n || (2 * rem == n && q[0])) q++;
      return q[7:0];
   endfunction

   // Predicts every output word that one source pixel completes.
   task automatic upsample_pixel(input ups2x_pkg::req_type px);
      int unsigned        w, h, c, r, nr, nc, n, sum;
      int unsigned        ry [3];
      int unsigned        cx [3];
      logic [1:0]         rsel [3];
      logic [1:0]         csel [3];
      ups2x_pkg::pix_type quad [4];
      logic [7:0]         chan [3];
      ups2x_pkg::rsp_type word;
      logic               frame_end;
      w = eff_width();
      h = eff_height();
      c = next_col;
      r = next_row;
      if (c >= w) c = 0;
      if (r >= h) r = 0;

      // Neighborhood: above-left, above, left, current.
      quad[0] = upleft_px;
      quad[1] = (r > 0) ? prior_row[c] : '0;
      quad[2] = left_px;
      quad[3] = {px.ch2_in, px.ch1_in, px.ch0_in};

      // Output rows and columns this pixel completes; bit 0 selects the
      // previous source row or column, bit 1 the current one.
      nr = 0;
      nc = 0;
      if (r > 0) begin
         ry[nr] = 2 * r - 1; rsel[nr] = 2'b11; nr++;
      end
      ry[nr] = 2 * r; rsel[nr] = 2'b10; nr++;
      if (r == h - 1 && h % 2 == 0) begin
         ry[nr] = 2 * r + 1; rsel[nr] = 2'b10; nr++;
      end
      if (c > 0) begin
         cx[nc] = 2 * c - 1; csel[nc] = 2'b11; nc++;
      end
      cx[nc] = 2 * c; csel[nc] = 2'b10; nc++;
      if (c == w - 1 && w % 2 == 0) begin
         cx[nc] = 2 * c + 1; csel[nc] = 2'b10; nc++;
      end
      frame_end = (r == h - 1) && (c == w - 1);

      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            n = ((rsel[i] == 2'b11) ? 2 : 1) * ((csel[j] == 2'b11) ? 2 : 1);
            for (int ch = 0; ch < 3; ch++) begin
               sum = 0;
               for (int a = 0; a < 2; a++) begin
                  for (int b = 0; b < 2; b++) begin
                     if (rsel[i][a] && csel[j][b]) sum += quad[a * 2 + b][8 * ch +: 8];
                  end
               end
               chan[ch] = mean_rne(sum, n);
            end
            word.ch0_out       = chan[0];
            word.ch1_out       = chan[1];
            word.ch2_out       = chan[2];
            word.out_row       = ry[i][12:0];
            word.out_col       = cx[j][11:0];
            word.last_of_run   = (i == nr - 1) && (j == nc - 1);
            word.last_of_frame = word.last_of_run && frame_end;
            pending_pixels.push_back(word);
         end
      end

      // Advance the model state.
      upleft_px    = quad[1];
      left_px      = quad[3];
      prior_row[c] = quad[3];
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      next_col = c;
      next_row = r;
   endtask

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Random pixel, with full-scale channel values now and then.
   function automatic ups2x_pkg::req_type draw_pixel();
      logic [7:0] v [3];
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(0, 7))
            0:       v[ch] = 8'h00;
            1:       v[ch] = 8'hFF;
            default: v[ch] = 8'($urandom_range(0, 255));
         endcase
      end
      return ups2x_pkg::req_type'{v[0], v[1], v[2]};
   endfunction

   // Sends one source pixel; valid stays high for a back-to-back word.
   task automatic send_pixel(input ups2x_pkg::req_type px);
      int unsigned gap;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      upsample_pixel(px);
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // Writes one register; hold keeps valid high for a following write.
   task automatic write_reg(input logic [ups2x_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ups2x_pkg::CSR_DATA_W-1:0] val, input bit hold);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (!hold) csr_valid <= 1'b0;
      reg_writes++;
      // Known registers restart the frame; others are ignored.
      if (idx == ups2x_pkg::CSR_SRC_WIDTH) begin
         reg_width = 32'(val[11:0]);
         next_col  = 0;
         next_row  = 0;
      end else if (idx == ups2x_pkg::CSR_SRC_HEIGHT) begin
         reg_height = 32'(val);
         next_col   = 0;
         next_row   = 0;
      end
   endtask

   task automatic set_size(input logic [ups2x_pkg::CSR_DATA_W-1:0] w,
                           input logic [ups2x_pkg::CSR_DATA_W-1:0] h);
      write_reg(ups2x_pkg::CSR_SRC_WIDTH, w, 1'b1);
      write_reg(ups2x_pkg::CSR_SRC_HEIGHT, h, 1'b0);
   endtask

   // Stops input and waits until every predicted word has come out.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Output side: random stalls and checking
   // ------------------------------------------------------------------------

   // After each word taken, stall for a freshly drawn number of cycles.
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      int unsigned n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         n = rx_burst ? 0 : $urandom_range(0, 19);
         stall_left <= n;
         rsp_stall  <= (n != 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   task automatic check_field(input string name, input logic [12:0] want,
                              input logic [12:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Compares each accepted output word with the oldest prediction.
   always @(posedge clock) begin
      ups2x_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (pending_pixels.size() == 0) begin
            $error("output word row %0d col %0d with none expected",
                   rsp_data.out_row, rsp_data.out_col);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("ch0_out", 13'(want.ch0_out), 13'(rsp_data.ch0_out));
            check_field("ch1_out", 13'(want.ch1_out), 13'(rsp_data.ch1_out));
            check_field("ch2_out", 13'(want.ch2_out), 13'(rsp_data.ch2_out));
            check_field("out_row", want.out_row, rsp_data.out_row);
            check_field("out_col", 13'(want.out_col), 13'(rsp_data.out_col));
            check_field("last_of_run", 13'(want.last_of_run), 13'(rsp_data.last_of_run));
            check_field("last_of_frame", 13'(want.last_of_frame),
                        13'(rsp_data.last_of_frame));
         end
      end
   end

   // Ends the run when no handshake happens for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d words outstanding",
                  WATCHDOG_LIMIT, pending_pixels.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Start of the first row at the reset size, with full-scale and alternating bits.
   task automatic test_reset_size();
      send_pixel(ups2x_pkg::req_type'{8'h00, 8'h00, 8'h00});
      send_pixel(ups2x_pkg::req_type'{8'hFF, 8'hFF, 8'hFF});
      send_pixel(ups2x_pkg::req_type'{8'hAA, 8'h55, 8'hAA});
      send_pixel(ups2x_pkg::req_type'{8'h55, 8'hAA, 8'h55});
      drain();
   endtask

   // Zero sizes act as one pixel; every pixel is then a whole frame.
   task automatic test_single_pixel();
      set_size(13'd0, 13'd0);
      send_pixel(draw_pixel());
      send_pixel(draw_pixel());
      drain();
      set_size(13'd1, 13'd1);
      send_pixel(draw_pixel());
      drain();
   endtask

   // A 2x2 frame: the last pixel completes nine words, with rounding ties.
   task automatic test_rounding_2x2();
      tx_burst = 1'b0;
      rx_burst = 1'b0;
      set_size(13'd2, 13'd2);
      send_pixel(ups2x_pkg::req_type'{8'd0, 8'd1, 8'd255});
      send_pixel(ups2x_pkg::req_type'{8'd1, 8'd2, 8'd254});
      send_pixel(ups2x_pkg::req_type'{8'd1, 8'd1, 8'd255});
      send_pixel(ups2x_pkg::req_type'{8'd0, 8'd2, 8'd255});
      repeat (4) send_pixel(draw_pixel());
      drain();
   endtask

   // Odd 3x3 frame; the width write carries a bit above the register width,
   // and a write to an unused index mid-frame must not restart the frame.
   task automatic test_odd_3x3();
      tx_burst = 1'b1;
      set_size(13'h1003, 13'd3);
      repeat (4) send_pixel(draw_pixel());
      drain();
      write_reg(CSR_UNUSED, 13'($urandom_range(0, 8191)), 1'b0);
      tx_burst = 1'b0;
      repeat (5) send_pixel(draw_pixel());
      drain();
   endtask

   // Oversized width saturates to the line store size; the start of a row at
   // that width, then a short run at the full width with a height of two rows.
   task automatic test_wide_row();
      tx_burst = ($urandom_range(0, 1) == 0);
      rx_burst = ($urandom_range(0, 1) == 0);
      set_size(13'h0FFF, 13'd1);
      repeat (5) send_pixel(draw_pixel());
      drain();
      set_size(13'(ups2x_pkg::MAX_WIDTH_DEF), 13'd2);
      repeat (5) send_pixel(draw_pixel());
      drain();
   endtask

   // Oversized height saturates; the top of a one-pixel-wide column.
   task automatic test_tall_column();
      tx_burst = ($urandom_range(0, 1) == 0);
      rx_burst = ($urandom_range(0, 1) == 0);
      set_size(13'd1, 13'h1FFF);
      repeat (5) send_pixel(draw_pixel());
      drain();
      set_size(13'd1, 13'(ups2x_pkg::HEIGHT_LIMIT));
      repeat (5) send_pixel(draw_pixel());
      drain();
   endtask

   // Mostly whole small frames with random content; some frames are cut
   // short or run into the next one before the size changes again.
   task automatic test_random_frames();
      int unsigned sent, w, h, count, frame_px;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         rx_burst = ($urandom_range(0, 3) == 0);
         w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
         if ($urandom_range(0, 4) == 0) write_reg(ups2x_pkg::CSR_SRC_HEIGHT, 13'(h), 1'b0);
         else set_size(13'(w), 13'(h));
         frame_px = eff_width() * eff_height();
         case ($urandom_range(0, 3))
            0:       count = $urandom_range(1, frame_px);
            1:       count = frame_px + $urandom_range(1, frame_px);
            default: count = frame_px;
         endcase
         repeat (count) send_pixel(draw_pixel());
         sent += count;
         drain();
      end
   endtask

   initial begin
      reg_width  = 32'(ups2x_pkg::SRC_WIDTH_RST);
      reg_height = 32'(ups2x_pkg::SRC_HEIGHT_RST);
      left_px    = '0;
      upleft_px  = '0;
      next_col   = 0;
      next_row   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_single_pixel();
      test_rounding_2x2();
      test_odd_3x3();
      test_wide_row();
      test_tall_column();
      test_random_frames();
      drain();

      $display("Sent %0d source pixels with %0d register writes; checked %0d output words.",
               pixels_sent, reg_writes, words_checked);
      $display("Sizes ran from one pixel up to saturated width and height registers.");
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
